[rtl/core/cpio_pkg.sv]
package cpio_pkg;

    localparam int unsigned HDR_LEN     = 110;
    localparam int unsigned MAGIC_LEN   = 6;
    localparam int unsigned TRAILER_LEN = 11;

    localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{
        8'h30, 8'h37, 8'h30, 8'h37, 8'h30, 8'h31
    };

    // "TRAILER!!!" and its terminating NUL
    localparam logic [7:0] TRAILER_BYTES [TRAILER_LEN] = '{
        8'h54, 8'h52, 8'h41, 8'h49, 8'h4C, 8'h45, 8'h52, 8'h21, 8'h21, 8'h21, 8'h00
    };

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [4:0] HEX_A_VALUE  = 5'd10;

    // header field slots that are kept
    localparam logic [3:0] FLD_INO      = 4'd0;
    localparam logic [3:0] FLD_MODE     = 4'd1;
    localparam logic [3:0] FLD_FILESIZE = 4'd6;
    localparam logic [3:0] FLD_NAMESIZE = 4'd11;

    localparam logic [2:0] CLS_HEADER   = 3'd0;
    localparam logic [2:0] CLS_NAME     = 3'd1;
    localparam logic [2:0] CLS_NAMEPAD  = 3'd2;
    localparam logic [2:0] CLS_DATA     = 3'd3;
    localparam logic [2:0] CLS_DATAPAD  = 3'd4;
    localparam logic [2:0] CLS_END      = 3'd5;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NAME,
        PH_NAMEPAD,
        PH_DATA,
        PH_DATAPAD,
        PH_END
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_value;
    } t_byte;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  byte_echo;
        logic [15:0] file_number;
        logic        data_last;
        logic        record_valid;
        logic        is_trailer;
        logic [31:0] inode_number;
        logic [31:0] file_mode;
        logic [31:0] data_size;
        logic [31:0] name_length;
        logic        bad_magic;
    } t_record;

endpackage

[rtl/core/cpio_if.sv]
interface cpio_byte_if;
    logic           valid;
    logic           ready;
    cpio_pkg::t_byte data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpio_record_if;
    logic              valid;
    logic              ready;
    cpio_pkg::t_record data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/cpio_newc_archive_walker_top.sv]
// Channel   Dir  Modport  Word
// i_in      in   sink     one archive byte (byte_value)
// o_out     out  source   byte class, echo, member number and header record
//
// Each byte is worked on in the cycle it is accepted; its word is registered into a
// two-entry output buffer and leaves from there, so one byte is taken every cycle unless the buffer is full.
// Input ready drops only while both buffer entries are full.
// Reset (i_rst_n low at a clock edge) returns the walker to the first header
// byte and empties the output buffer.
module cpio_newc_archive_walker_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cpio_byte_if.sink            i_in,
    cpio_record_if.source        o_out
);

    cpio_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_region, n_region;
    logic [31:0] r_accum, n_accum;
    logic [31:0] r_ino, n_ino;
    logic [31:0] r_mode, n_mode;
    logic [31:0] r_size, n_size;
    logic [31:0] r_namesize, n_namesize;
    logic [3:0]  r_tr_idx, n_tr_idx;
    logic        r_tr_ok, n_tr_ok;
    logic [15:0] r_member, n_member;
    logic        r_halt, n_halt;

    // output buffer: entry 0 is the head
    cpio_pkg::t_record r_q0, n_q0, r_q1, n_q1;
    logic r_v0, n_v0, r_v1, n_v1;

    logic [7:0]  w_c;
    logic        w_put, w_take;
    logic [6:0]  w_j;
    logic [31:0] w_digit, w_base, w_acc;
    logic [3:0]  w_fld;
    logic [1:0]  w_name_pad, w_data_pad;
    // where the walk goes after the name (and after any name pad)
    cpio_pkg::t_phase w_ed_phase, w_an_phase;
    logic [31:0] w_ed_region, w_an_region;
    logic        w_ed_next, w_an_next;

    cpio_pkg::t_record w_res;
    logic [2:0] w_cls;
    logic       w_dl, w_rv, w_tr, w_ok_new;
    logic [3:0] w_idx_new;

    assign w_c    = i_in.data.byte_value;
    assign w_put  = i_in.valid && i_in.ready;
    assign w_take = r_v0 && o_out.ready;

    assign i_in.ready  = !r_v1;
    assign o_out.valid = r_v0;
    assign o_out.data  = r_q0;

    // hex field accumulation
    assign w_j     = r_region[6:0] - 7'(cpio_pkg::MAGIC_LEN);
    assign w_fld   = w_j[6:3];
    assign w_digit = (w_c >= cpio_pkg::CHAR_UPPER_A && w_c <= cpio_pkg::CHAR_UPPER_F)
                   ? 32'(w_c - cpio_pkg::CHAR_UPPER_A) + 32'(cpio_pkg::HEX_A_VALUE)
                   : 32'(w_c) - 32'(cpio_pkg::CHAR_ZERO);
    assign w_base  = (w_j[2:0] == 3'd0) ? 32'd0 : r_accum;
    assign w_acc   = (w_base << 4) + w_digit;

    // pads count from archive start: header is 110 bytes, i.e. 2 mod 4
    assign w_name_pad = 2'd0 - (2'd2 + r_namesize[1:0]);
    assign w_data_pad = 2'd0 - r_size[1:0];

    always_comb begin
        if (r_size != 32'd0) begin
            w_ed_phase  = cpio_pkg::PH_DATA;
            w_ed_region = r_size;
            w_ed_next   = 1'b0;
        end else begin
            w_ed_phase  = cpio_pkg::PH_HEADER;
            w_ed_region = 32'd0;
            w_ed_next   = 1'b1;
        end
        if (w_name_pad != 2'd0) begin
            w_an_phase  = cpio_pkg::PH_NAMEPAD;
            w_an_region = 32'(w_name_pad);
            w_an_next   = 1'b0;
        end else begin
            w_an_phase  = w_ed_phase;
            w_an_region = w_ed_region;
            w_an_next   = w_ed_next;
        end
    end

    assign w_ok_new  = (r_tr_idx < 4'(cpio_pkg::TRAILER_LEN))
                     ? (r_tr_ok && (w_c == cpio_pkg::TRAILER_BYTES[r_tr_idx]))
                     : r_tr_ok;
    assign w_idx_new = (r_tr_idx < 4'(cpio_pkg::TRAILER_LEN)) ? r_tr_idx + 4'd1 : r_tr_idx;

    // walker next state
    always_comb begin
        n_phase    = r_phase;
        n_region   = r_region;
        n_accum    = r_accum;
        n_ino      = r_ino;
        n_mode     = r_mode;
        n_size     = r_size;
        n_namesize = r_namesize;
        n_tr_idx   = r_tr_idx;
        n_tr_ok    = r_tr_ok;
        n_member   = r_member;
        n_halt     = r_halt;
        w_cls      = cpio_pkg::CLS_END;
        w_dl       = 1'b0;
        w_rv       = 1'b0;
        w_tr       = 1'b0;

        if (w_put && !r_halt) begin
            unique case (r_phase)
                cpio_pkg::PH_HEADER: begin
                    w_cls = cpio_pkg::CLS_HEADER;
                    if (r_region < 32'(cpio_pkg::MAGIC_LEN)) begin
                        if (w_c != cpio_pkg::MAGIC_BYTES[r_region[2:0]]) begin
                            n_halt  = 1'b1;
                            n_phase = cpio_pkg::PH_END;
                        end else begin
                            n_region = r_region + 32'd1;
                        end
                    end else begin
                        n_accum = w_acc;
                        if (w_j[2:0] == 3'd7) begin
                            if (w_fld == cpio_pkg::FLD_INO)      n_ino      = w_acc;
                            if (w_fld == cpio_pkg::FLD_MODE)     n_mode     = w_acc;
                            if (w_fld == cpio_pkg::FLD_FILESIZE) n_size     = w_acc;
                            if (w_fld == cpio_pkg::FLD_NAMESIZE) n_namesize = w_acc;
                        end
                        if (r_region == 32'(cpio_pkg::HDR_LEN - 1)) begin
                            if (r_namesize == 32'd0) begin
                                w_rv     = 1'b1;
                                n_phase  = w_an_phase;
                                n_region = w_an_region;
                                if (w_an_next) n_member = r_member + 16'd1;
                            end else begin
                                n_phase  = cpio_pkg::PH_NAME;
                                n_region = r_namesize;
                                n_tr_idx = 4'd0;
                                n_tr_ok  = 1'b1;
                            end
                        end else begin
                            n_region = r_region + 32'd1;
                        end
                    end
                end
                cpio_pkg::PH_NAME: begin
                    w_cls    = cpio_pkg::CLS_NAME;
                    n_tr_idx = w_idx_new;
                    n_tr_ok  = w_ok_new;
                    n_region = r_region - 32'd1;
                    if (r_region == 32'd1) begin
                        w_rv = 1'b1;
                        w_tr = w_ok_new && (w_idx_new >= 4'(cpio_pkg::TRAILER_LEN));
                        if (w_tr) begin
                            n_phase = cpio_pkg::PH_END;
                        end else begin
                            n_phase  = w_an_phase;
                            n_region = w_an_region;
                            if (w_an_next) n_member = r_member + 16'd1;
                        end
                    end
                end
                cpio_pkg::PH_NAMEPAD: begin
                    w_cls    = cpio_pkg::CLS_NAMEPAD;
                    n_region = r_region - 32'd1;
                    if (r_region == 32'd1) begin
                        n_phase  = w_ed_phase;
                        n_region = w_ed_region;
                        if (w_ed_next) n_member = r_member + 16'd1;
                    end
                end
                cpio_pkg::PH_DATA: begin
                    w_cls    = cpio_pkg::CLS_DATA;
                    n_region = r_region - 32'd1;
                    if (r_region == 32'd1) begin
                        w_dl = 1'b1;
                        if (w_data_pad != 2'd0) begin
                            n_phase  = cpio_pkg::PH_DATAPAD;
                            n_region = 32'(w_data_pad);
                        end else begin
                            n_phase  = cpio_pkg::PH_HEADER;
                            n_region = 32'd0;
                            n_member = r_member + 16'd1;
                        end
                    end
                end
                cpio_pkg::PH_DATAPAD: begin
                    w_cls    = cpio_pkg::CLS_DATAPAD;
                    n_region = r_region - 32'd1;
                    if (r_region == 32'd1) begin
                        n_phase  = cpio_pkg::PH_HEADER;
                        n_region = 32'd0;
                        n_member = r_member + 16'd1;
                    end
                end
                default: begin
                    w_cls = cpio_pkg::CLS_END;
                end
            endcase
        end
    end

    always_comb begin
        w_res.byte_class   = w_cls;
        w_res.byte_echo    = w_c;
        w_res.file_number  = r_member;
        w_res.data_last    = w_dl;
        w_res.record_valid = w_rv;
        w_res.is_trailer   = w_tr;
        w_res.inode_number = w_rv ? r_ino : 32'd0;
        w_res.file_mode    = w_rv ? r_mode : 32'd0;
        w_res.data_size    = w_rv ? r_size : 32'd0;
        w_res.name_length  = w_rv ? r_namesize : 32'd0;
        w_res.bad_magic    = n_halt;
    end

    // output buffer: drop the head when taken, then push the new word
    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        n_v0 = r_v0;
        n_v1 = r_v1;
        if (w_take) begin
            n_q0 = r_q1;
            n_v0 = r_v1;
            n_v1 = 1'b0;
        end
        if (w_put) begin
            if (!n_v0) begin
                n_q0 = w_res;
                n_v0 = 1'b1;
            end else begin
                n_q1 = w_res;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cpio_pkg::PH_HEADER;
            r_region   <= 32'd0;
            r_accum    <= 32'd0;
            r_ino      <= 32'd0;
            r_mode     <= 32'd0;
            r_size     <= 32'd0;
            r_namesize <= 32'd0;
            r_tr_idx   <= 4'd0;
            r_tr_ok    <= 1'b1;
            r_member   <= 16'd0;
            r_halt     <= 1'b0;
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_region   <= n_region;
            r_accum    <= n_accum;
            r_ino      <= n_ino;
            r_mode     <= n_mode;
            r_size     <= n_size;
            r_namesize <= n_namesize;
            r_tr_idx   <= n_tr_idx;
            r_tr_ok    <= n_tr_ok;
            r_member   <= n_member;
            r_halt     <= n_halt;
            r_v0       <= n_v0;
            r_v1       <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule
